/* rtl/ertm_pkg.sv */
// ----------------------------------------------------------------------------
// ertm_pkg
// Shared types and constants for the euler angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package ertm_pkg;

    localparam int ITERS      = 30;
    localparam int LANE_STG   = ITERS + 2;
    localparam int NSTG       = LANE_STG + 5;

    localparam logic signed [31:0] Q30_ONE   = 32'sd1073741824;
    localparam logic signed [31:0] GAIN_INV  = 32'sd652032874;
    localparam logic signed [33:0] Q30_PI    = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI   = 34'sd1686629713;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [31:0] q30_t;
    typedef q30_t mat_t [9];

    function automatic q30_t atan_q30(input int idx);
        q30_t r;
        r = 32'sd0;
        unique case (idx)
            0:  r = 32'sh3243F6A8;
            1:  r = 32'sh1DAC6705;
            2:  r = 32'sh0FADBAFC;
            3:  r = 32'sh07F56EA6;
            4:  r = 32'sh03FEAB76;
            5:  r = 32'sh01FFD55B;
            6:  r = 32'sh00FFFAAA;
            7:  r = 32'sh007FFF55;
            8:  r = 32'sh003FFFEA;
            9:  r = 32'sh001FFFFD;
            10: r = 32'sh000FFFFF;
            11: r = 32'sh0007FFFF;
            12: r = 32'sh0003FFFF;
            13: r = 32'sh0001FFFF;
            14: r = 32'sh0000FFFF;
            15: r = 32'sh00007FFF;
            16: r = 32'sh00003FFF;
            17: r = 32'sh00001FFF;
            18: r = 32'sh00000FFF;
            19: r = 32'sh000007FF;
            20: r = 32'sh000003FF;
            21: r = 32'sh000001FF;
            22: r = 32'sh000000FF;
            23: r = 32'sh0000007F;
            24: r = 32'sh0000003F;
            25: r = 32'sh0000001F;
            26: r = 32'sh0000000F;
            27: r = 32'sh00000008;
            28: r = 32'sh00000004;
            29: r = 32'sh00000002;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ertm_cordic_lane.sv */
// ----------------------------------------------------------------------------
// ertm_cordic_lane
// Pipelined rotation-mode cordic for one angle and the elementary rotation
// matrix built from its sine and cosine.
// ----------------------------------------------------------------------------
module ertm_cordic_lane
(
    input  logic                          clk,
    input  logic [ertm_pkg::LANE_STG-1:0] en,
    input  logic signed [15:0]            angle,
    input  logic [1:0]                    axis,
    output ertm_pkg::mat_t                rot
);

    localparam int N = ertm_pkg::ITERS;

    ertm_pkg::q30_t x_reg [N+1];
    ertm_pkg::q30_t y_reg [N+1];
    ertm_pkg::q30_t z_reg [N+1];
    logic           neg_reg  [N+1];
    logic [1:0]     axis_reg [N+1];

    logic signed [33:0] z_full;
    logic signed [33:0] z_fold;
    logic               neg_next;

    always_comb
    begin
        z_full = {angle[15], angle, 17'b0};
        z_fold = z_full;
        neg_next = 1'b0;
        if (z_full > ertm_pkg::HALF_PI)
        begin
            z_fold = z_full - ertm_pkg::Q30_PI;
            neg_next = 1'b1;
        end
        else if (z_full < -ertm_pkg::HALF_PI)
        begin
            z_fold = z_full + ertm_pkg::Q30_PI;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= ertm_pkg::GAIN_INV;
            y_reg[0]    <= 32'sd0;
            z_reg[0]    <= z_fold[31:0];
            neg_reg[0]  <= neg_next;
            axis_reg[0] <= axis;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_iter
        ertm_pkg::q30_t xs;
        ertm_pkg::q30_t ys;
        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;
        always_ff @(posedge clk)
        begin
            if (en[k+1])
            begin
                if (!z_reg[k][31])
                begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - ertm_pkg::atan_q30(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + ertm_pkg::atan_q30(k);
                end
                neg_reg[k+1]  <= neg_reg[k];
                axis_reg[k+1] <= axis_reg[k];
            end
        end
    end

    ertm_pkg::q30_t c;
    ertm_pkg::q30_t s;
    ertm_pkg::mat_t rot_next;
    ertm_pkg::mat_t rot_reg;

    always_comb
    begin
        c = neg_reg[N] ? -x_reg[N] : x_reg[N];
        s = neg_reg[N] ? -y_reg[N] : y_reg[N];
        for (int i = 0; i < 9; i++)
        begin
            rot_next[i] = 32'sd0;
        end
        rot_next[0] = ertm_pkg::Q30_ONE;
        rot_next[4] = ertm_pkg::Q30_ONE;
        rot_next[8] = ertm_pkg::Q30_ONE;
        unique case (axis_reg[N])
            ertm_pkg::AXIS_X:
            begin
                rot_next[4] = c;
                rot_next[5] = -s;
                rot_next[7] = s;
                rot_next[8] = c;
            end
            ertm_pkg::AXIS_Y:
            begin
                rot_next[0] = c;
                rot_next[2] = s;
                rot_next[6] = -s;
                rot_next[8] = c;
            end
            ertm_pkg::AXIS_Z:
            begin
                rot_next[0] = c;
                rot_next[1] = -s;
                rot_next[3] = s;
                rot_next[4] = c;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[N+1])
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

/* rtl/ertm_matmul.sv */
// ----------------------------------------------------------------------------
// ertm_matmul
// Two-stage 3x3 matrix product in q2.30: registered products, then sum and
// round half up.
// ----------------------------------------------------------------------------
module ertm_matmul
(
    input  logic           clk,
    input  logic [1:0]     en,
    input  ertm_pkg::mat_t a,
    input  ertm_pkg::mat_t b,
    output ertm_pkg::mat_t r
);

    logic signed [63:0] prod_reg [27];
    ertm_pkg::mat_t     r_reg;
    ertm_pkg::mat_t     r_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int row = 0; row < 3; row++)
            begin
                for (int col = 0; col < 3; col++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[(row*3+col)*3+k] <= a[row*3+k] * b[k*3+col];
                    end
                end
            end
        end
    end

    always_comb
    begin
        logic signed [65:0] acc;
        for (int e = 0; e < 9; e++)
        begin
            acc = 66'(prod_reg[e*3]) + 66'(prod_reg[e*3+1]) + 66'(prod_reg[e*3+2])
                + (66'sd1 <<< 29);
            acc = acc >>> 30;
            r_next[e] = acc[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

/* rtl/euler_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Rotation matrix from three angles about chosen axes.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled. Three cordic
// lanes (32 stages each: an angle fold, a stage per iteration and the
// matrix build) work on the three angles in parallel, two pipelined 3x3
// products merge the lanes, and a final stage rounds and saturates. Each
// stage holds while it and all later stages are full and the output is stalled,
// so bubbles are squeezed out and items keep entering until the pipe fills.
module euler_to_rotation_matrix
#(
    parameter int RESULT_FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] angle_first,
    input  logic signed [15:0] angle_second,
    input  logic signed [15:0] angle_third,
    input  logic [1:0]         axis_first,
    input  logic [1:0]         axis_second,
    input  logic [1:0]         axis_third,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int NS = ertm_pkg::NSTG;
    localparam int LS = ertm_pkg::LANE_STG;
    localparam int SH = 30 - RESULT_FRAC_BITS;
    localparam logic signed [33:0] RND =
        (SH > 0) ? (34'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 34'sd0;
    localparam logic signed [33:0] LIM = 34'sd1 <<< RESULT_FRAC_BITS;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    for (genvar i = 0; i < NS; i++)
    begin : g_en
        assign en[i] = out_ready | ~&(vld_reg | NS'((64'd1 << i) - 64'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    ertm_pkg::mat_t rot0, rot1, rot2, t, r;
    ertm_pkg::mat_t rot2_d1_reg, rot2_d2_reg;

    ertm_cordic_lane u_lane0 (.clk(clk), .en(en[LS-1:0]), .angle(angle_first),
                              .axis(axis_first), .rot(rot0));
    ertm_cordic_lane u_lane1 (.clk(clk), .en(en[LS-1:0]), .angle(angle_second),
                              .axis(axis_second), .rot(rot1));
    ertm_cordic_lane u_lane2 (.clk(clk), .en(en[LS-1:0]), .angle(angle_third),
                              .axis(axis_third), .rot(rot2));

    ertm_matmul u_mm0 (.clk(clk), .en(en[LS+1:LS]), .a(rot0), .b(rot1), .r(t));

    always_ff @(posedge clk)
    begin
        if (en[LS])
        begin
            rot2_d1_reg <= rot2;
        end
        if (en[LS+1])
        begin
            rot2_d2_reg <= rot2_d1_reg;
        end
    end

    ertm_matmul u_mm1 (.clk(clk), .en(en[LS+3:LS+2]), .a(t), .b(rot2_d2_reg), .r(r));

    logic [15:0] out_reg  [9];
    logic [15:0] out_next [9];

    always_comb
    begin
        logic signed [33:0] v;
        for (int j = 0; j < 9; j++)
        begin
            v = (34'(r[j]) + RND) >>> SH;
            if (v > LIM)
            begin
                v = LIM;
            end
            if (v < -LIM)
            begin
                v = -LIM;
            end
            out_next[j] = v[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m02 = out_reg[2];
    assign m10 = out_reg[3];
    assign m11 = out_reg[4];
    assign m12 = out_reg[5];
    assign m20 = out_reg[6];
    assign m21 = out_reg[7];
    assign m22 = out_reg[8];

endmodule

/* rtl/ertm_checker.sv */
// ----------------------------------------------------------------------------
// ertm_checker
// Port-level checks for the rotation matrix pipeline.
// ----------------------------------------------------------------------------
module ertm_checker
#(
    parameter int RESULT_FRAC_BITS = 14
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] angle_first,
    input logic signed [15:0] angle_second,
    input logic signed [15:0] angle_third,
    input logic [1:0]         axis_first,
    input logic [1:0]         axis_second,
    input logic [1:0]         axis_third,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] m00,
    input logic signed [15:0] m01,
    input logic signed [15:0] m02,
    input logic signed [15:0] m10,
    input logic signed [15:0] m11,
    input logic signed [15:0] m12,
    input logic signed [15:0] m20,
    input logic signed [15:0] m21,
    input logic signed [15:0] m22
);

    localparam int LIM = 1 << ((RESULT_FRAC_BITS > 14) ? 14 : RESULT_FRAC_BITS);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no item waiting at output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(m00) && $stable(m11) && $stable(m22))
        else $error("output item changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (RESULT_FRAC_BITS > 14) ||
            (m00 <= LIM && m00 >= -LIM && m11 <= LIM && m11 >= -LIM &&
             m22 <= LIM && m22 >= -LIM))
        else $error("matrix entry outside saturation range");

endmodule

bind euler_to_rotation_matrix ertm_checker #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_chk (.*);
